// ===== rtl/core/shfd_pkg.sv =====
// ----------------------------------------------------------------------------
// shfd_pkg
// Shared types, constants and the half-band coefficient table for the
// stereo half-band FIR decimator.
// ----------------------------------------------------------------------------
package shfd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int RING_DEPTH   = 64;
  localparam int RING_AW      = 6;
  localparam int COEF_W       = 16;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  // Sum of |coef| is 47526, times 2^15 stays below 2^31.
  localparam int ACC_W        = 32;
  localparam int COEF_SHIFT   = 15;
  localparam int TAP_COUNT_DEF = 39;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [RING_AW-1:0]         ring_addr_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
    logic    emit;
  } in_beat_t;

  typedef struct packed {
    sample_t filtered_left;
    sample_t filtered_right;
  } out_beat_t;

  typedef struct packed {
    logic       en;
    ring_addr_t addr;
  } ring_wr_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctl_t;

  // Symmetric 39-tap half-band set, oldest sample first; zero past the end.
  function automatic coef_t hb_coef(input ring_addr_t idx);
    coef_t c;
    case (idx)
      6'd0, 6'd38:  c = -16'sd1;
      6'd2, 6'd36:  c = 16'sd2;
      6'd4, 6'd34:  c = -16'sd10;
      6'd6, 6'd32:  c = 16'sd35;
      6'd8, 6'd30:  c = -16'sd103;
      6'd10, 6'd28: c = 16'sd266;
      6'd12, 6'd26: c = -16'sd616;
      6'd14, 6'd24: c = 16'sd1332;
      6'd16, 6'd22: c = -16'sd2960;
      6'd18, 6'd20: c = 16'sd10246;
      6'd19:        c = 16'sd16384;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/shfd_ring.sv =====
// ----------------------------------------------------------------------------
// shfd_ring
// Left and right 64-entry sample rings with one write and one registered
// read port. Per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module shfd_ring
  import shfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ring_wr_t   wr,
  input  sample_t    wr_left,
  input  sample_t    wr_right,
  input  ring_addr_t rd_addr,
  output sample_t    rd_left,
  output sample_t    rd_right
);

  sample_t                mem_left  [RING_DEPTH];
  sample_t                mem_right [RING_DEPTH];
  logic [RING_DEPTH-1:0]  vld_r;
  sample_t                rd_left_r;
  sample_t                rd_right_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_left[wr.addr]  <= wr_left;
      mem_right[wr.addr] <= wr_right;
    end
    rd_left_r  <= mem_left[rd_addr];
    rd_right_r <= mem_right[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_left  = rd_vld_r ? rd_left_r  : '0;
  assign rd_right = rd_vld_r ? rd_right_r : '0;

endmodule

// ===== rtl/core/shfd_mac.sv =====
// ----------------------------------------------------------------------------
// shfd_mac
// Two-lane multiply-accumulate unit shared over all taps, with product
// register, accumulator and the final shift and saturation.
// ----------------------------------------------------------------------------
module shfd_mac
  import shfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  sample_t  smp_left,
  input  sample_t  smp_right,
  input  coef_t    coef,
  output logic     prod_vld,
  output sample_t  sat_left,
  output sample_t  sat_right
);

  logic signed [PROD_W-1:0] prod_left_r;
  logic signed [PROD_W-1:0] prod_right_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_left_r;
  logic signed [ACC_W-1:0]  acc_right_r;

  function automatic sample_t sat16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-COEF_SHIFT-1:0] q;
    sample_t                            r;
    q = (ACC_W-COEF_SHIFT)'(acc >>> COEF_SHIFT);
    if (q > (ACC_W-COEF_SHIFT)'(32767)) begin
      r = 16'sh7fff;
    end else if (q < -(ACC_W-COEF_SHIFT)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_left_r  <= smp_left * coef;
      prod_right_r <= smp_right * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r  <= 1'b0;
      acc_left_r  <= '0;
      acc_right_r <= '0;
    end else begin
      prod_vld_r <= ctl.mul_en;
      if (ctl.clear) begin
        acc_left_r  <= '0;
        acc_right_r <= '0;
      end else if (prod_vld_r) begin
        acc_left_r  <= acc_left_r + ACC_W'(prod_left_r);
        acc_right_r <= acc_right_r + ACC_W'(prod_right_r);
      end
    end
  end

  assign prod_vld  = prod_vld_r;
  assign sat_left  = sat16(acc_left_r);
  assign sat_right = sat16(acc_right_r);

endmodule

// ===== rtl/core/stereo_halfband_fir_decimator.sv =====
// ----------------------------------------------------------------------------
// stereo_halfband_fir_decimator
// Stereo half-band FIR: stores each frame in a 64-entry ring per channel and,
// on request, filters both channels over the newest TAP_COUNT samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid / in_stall) carry one stereo frame and an emit
//   flag. Every frame is written to the rings and the write position wraps
//   modulo 64. A frame without emit leaves the block idle and gives no result.
//   A frame with emit starts a pass over the taps: one address per cycle,
//   both channels multiplied together by one shared two-lane MAC. The pass
//   loads the output register once the single MAC has walked the taps one
//   by one and the read, product and accumulate stages have drained.
//   in_stall stays high for the whole pass, so the next frame is taken only
//   after the pass has loaded the output register.
//   Results (out_valid / out_stall) leave from an output register; the next
//   frame is taken while a result waits. If a finished pass finds the output
//   register still held by a stalled beat, it waits until that beat leaves.
//   Reset clears the write position, the ring valid bits (unwritten entries
//   read as zero) and all handshake state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_halfband_fir_decimator
  import shfd_pkg::*;
#(
  parameter int TAP_COUNT = TAP_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam ring_addr_t TAP_LAST = RING_AW'(TAP_COUNT - 1);
  localparam ring_addr_t TAP_SPAN = RING_AW'(TAP_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  ring_addr_t wp_r, wp_nxt;
  ring_addr_t start_r, start_nxt;
  ring_addr_t tap_r, tap_nxt;
  logic       issue_r;
  coef_t      coef_r;
  logic       out_valid_r, out_valid_nxt;
  out_beat_t  out_data_r;
  logic       load;

  ring_wr_t   ring_wr;
  ring_addr_t rd_addr;
  sample_t    rd_left;
  sample_t    rd_right;
  mac_ctl_t   mac_ctl;
  logic       prod_vld;
  sample_t    sat_left;
  sample_t    sat_right;

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    start_nxt      = start_r;
    tap_nxt        = tap_r;
    ring_wr.en     = 1'b0;
    ring_wr.addr   = wp_r;
    mac_ctl.clear  = 1'b0;
    mac_ctl.mul_en = issue_r;
    load           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ring_wr.en = 1'b1;
          wp_nxt     = wp_r + 1'b1;
          if (in_data.emit) begin
            // window ends at the frame just written
            start_nxt     = wp_r + 1'b1 - TAP_SPAN;
            tap_nxt       = '0;
            mac_ctl.clear = 1'b1;
            state_nxt     = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        tap_nxt = tap_r + 1'b1;
        if (tap_r == TAP_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!issue_r && !prod_vld && (!out_valid_r || !out_stall)) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rd_addr  = start_r + tap_r;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      start_r     <= '0;
      tap_r       <= '0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      start_r     <= start_nxt;
      tap_r       <= tap_nxt;
      issue_r     <= (state_r == ST_RUN);
      out_valid_r <= out_valid_nxt;
    end
  end

  // coefficient lines up with the registered ring read
  always_ff @(posedge clk) begin
    coef_r <= hb_coef(tap_r);
    if (load) begin
      out_data_r.filtered_left  <= sat_left;
      out_data_r.filtered_right <= sat_right;
    end
  end

  shfd_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (ring_wr),
    .wr_left  (in_data.left_in),
    .wr_right (in_data.right_in),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  shfd_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .smp_left  (rd_left),
    .smp_right (rd_right),
    .coef      (coef_r),
    .prod_vld  (prod_vld),
    .sat_left  (sat_left),
    .sat_right (sat_right)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/shfd_chk.sv =====
// ----------------------------------------------------------------------------
// shfd_chk
// Port-level checks for the stereo half-band FIR decimator, bound to the
// top level.
// ----------------------------------------------------------------------------
module shfd_chk
  import shfd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a filter pass blocks the next frame
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.emit |=> in_stall)
    else $error("frame accepted during filter pass");

  // a frame without emit produces no result
  a_no_emit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.emit && !out_valid |=> !out_valid)
    else $error("result beat without emit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind stereo_halfband_fir_decimator shfd_chk u_shfd_chk (.*);
